### design/rdc_pkg.sv
`default_nettype none
package rdc_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 64;

  // input word: value in [63:0], radix in [71:64]
  localparam int IN_VALUE_W = 64;
  localparam int IN_RADIX_W = 8;
  localparam int IN_W       = IN_VALUE_W + IN_RADIX_W;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;

  localparam logic [IN_RADIX_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [IN_RADIX_W-1:0] RADIX_MAX = 8'd16;

  // quotient bits retired per cycle of the divider
  localparam int STEP_BITS = 8;
  localparam int STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS  = STEPS * STEP_BITS;
  localparam int STEP_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int COUNT_W = $clog2(MAX_DIGITS + 1);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic                  bad;
  } job_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h41;
      4'd11:   c = 8'h42;
      4'd12:   c = 8'h43;
      4'd13:   c = 8'h44;
      4'd14:   c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### design/radix_digit_converter_top.sv
`default_nettype none
// Flow: an item leaves the queue into the divider, which divides the value by the radix
//   once per digit (one radix step per digit, 8 quotient bits per cycle) and writes each
//   remainder to the digit store; the digits are then read back from the store, most
//   significant first, and each loads the output register. An out-of-range radix gives a
//   single error word.
// Queueing: the divider takes a new item only once it is done with the last; a two-word
//   input queue lets new items arrive while the divider works.
// Reset: rst is synchronous, active high; clears queue and control, not the digit store.
module radix_digit_converter_top
  import rdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // value [63:0], radix [71:64]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [CHAR_W-1:0] m_tdata,   // digit_char [7:0]
  output logic                   m_tlast,   // last_digit
  output logic                   m_tuser    // bad_radix
);

  logic job_valid;
  logic job_ready;
  job_t job;

  rdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  rdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

### design/rdc_ram.sv
`default_nettype none
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/rdc_front.sv
`default_nettype none
module rdc_front
  import rdc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,   // value [63:0], radix [71:64]
  output logic                 job_valid,
  input  wire logic            job_ready,
  output job_t                 job
);

  // two-entry queue between classification and the divider
  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  logic [IN_RADIX_W-1:0] radix_in;
  logic                  push;
  logic                  pop;
  job_t                  job_in;

  assign radix_in = s_tdata[IN_W-1:IN_VALUE_W];

  always_comb begin
    job_in.value = s_tdata[VALUE_BITS-1:0];
    job_in.radix = radix_in[RADIX_W-1:0];
    job_in.bad   = (radix_in < RADIX_MIN) || (radix_in > RADIX_MAX);
  end

  assign s_tready  = (fill != 2'd2);
  assign job_valid = (fill != 2'd0);
  assign job       = slot[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/rdc_back.sv
`default_nettype none
module rdc_back
  import rdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  job_t                   job,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [CHAR_W-1:0] m_tdata,   // digit_char [7:0]
  output logic                   m_tlast,   // last_digit
  output logic                   m_tuser    // bad_radix
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_ERR  = 3'd4;

  logic [2:0]          state;
  logic [PAD_BITS-1:0] quotient_reg;
  logic [PAD_BITS-1:0] quotient_next;
  logic [RADIX_W-1:0]  radix_reg;
  logic [COUNT_W-1:0]  digit_count;
  logic [COUNT_W-1:0]  count_inc;
  logic [DIGIT_W-1:0]  rem;
  logic [STEP_W-1:0]   step;
  logic [ADDR_W-1:0]   rd_idx;

  logic [STEP_BITS-1:0] qbits;
  logic [RADIX_W-1:0]   r;
  logic [RADIX_W-1:0]   t;

  logic                ram_we;
  logic                ram_re;
  logic [DIGIT_W-1:0]  ram_q;
  logic                out_free;
  logic                last_step;
  logic                word_load;

  // restoring division, STEP_BITS quotient bits per cycle; remainder stays below 16
  always_comb begin
    r     = {1'b0, rem};
    t     = '0;
    qbits = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r[DIGIT_W-1:0], quotient_reg[PAD_BITS-1-i]};
      if (t >= radix_reg) begin
        t = t - radix_reg;
        qbits[STEP_BITS-1-i] = 1'b1;
      end
      r = t;
    end
  end

  generate
    if (STEPS > 1) begin : g_shift
      assign quotient_next = {quotient_reg[PAD_BITS-STEP_BITS-1:0], qbits};
    end else begin : g_single
      assign quotient_next = qbits;
    end
  endgenerate

  assign count_inc = digit_count + 1'b1;
  assign last_step = (step == STEP_W'(STEPS - 1));
  assign out_free  = !m_tvalid || m_tready;
  assign job_ready = (state == ST_IDLE);
  assign ram_we    = (state == ST_DIV) && last_step;
  assign ram_re    = (state == ST_READ);
  assign word_load = ((state == ST_LOAD) || (state == ST_ERR)) && out_free;

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (r[DIGIT_W-1:0]),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      quotient_reg <= '0;
      radix_reg    <= '0;
      digit_count  <= '0;
      rem          <= '0;
      step         <= '0;
      rd_idx       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (word_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            if (job.bad) begin
              quotient_reg <= '0;
              radix_reg    <= '0;
              digit_count  <= '0;
              state        <= ST_ERR;
            end else begin
              quotient_reg <= PAD_BITS'(job.value);
              radix_reg    <= job.radix;
              digit_count  <= '0;
              rem          <= '0;
              step         <= '0;
              state        <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          quotient_reg <= quotient_next;
          if (last_step) begin
            rem         <= '0;
            step        <= '0;
            digit_count <= count_inc;
            if ((quotient_next == '0) || (count_inc == COUNT_W'(MAX_DIGITS))) begin
              rd_idx <= digit_count[ADDR_W-1:0];
              state  <= ST_READ;
            end
          end else begin
            rem  <= r[DIGIT_W-1:0];
            step <= step + 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            if (rd_idx == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_idx <= rd_idx - 1'b1;
              state  <= ST_READ;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output payload, loaded together with m_tvalid
  always_ff @(posedge clk) begin
    if ((state == ST_LOAD) && out_free) begin
      m_tdata <= glyph(ram_q);
      m_tlast <= (rd_idx == '0);
      m_tuser <= 1'b0;
    end else if ((state == ST_ERR) && out_free) begin
      m_tdata <= '0;
      m_tlast <= 1'b1;
      m_tuser <= 1'b1;
    end
  end

  a_div_radix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(16)))
    else $error("divider running with radix outside 2..16");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("error word not a single zero word");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (COUNT_W'(rd_idx) < digit_count))
    else $error("digit read beyond digits written");

  a_busy_pop: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !job_ready)
    else $error("queue popped while a job is in progress");

endmodule
`default_nettype wire
